>>> rtl/vhpd_pkg.sv
`timescale 1ns / 1ps

package vhpd_pkg;

	localparam int SET_CAPACITY = 4096;
	localparam int SLOT_W       = $clog2(SET_CAPACITY);
	localparam int EPOCH_W      = 8;
	localparam int KEY_W        = 64;
	localparam int COORD_W      = 32;
	localparam int LEAF_W       = 32;

	localparam logic [KEY_W-1:0]  HASH_BASIS     = 64'd1469598103934665603;
	localparam logic [KEY_W-1:0]  HASH_GOLDEN    = 64'h9e3779b97f4a7c15;
	localparam logic [LEAF_W-1:0] INV_LEAF_RESET = 32'd1310720;

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic                      frame_start;
	} point_t;

	typedef struct packed {
		logic             keep;
		logic             set_full;
		logic [KEY_W-1:0] voxel_key;
	} result_t;

	// epoch 0 marks a slot that no frame owns
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [KEY_W-1:0]   key;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_MIX,
		ST_PRIME,
		ST_PROBE,
		ST_HOLD
	} state_t;

	// h * 1099511628211 = h * (2^40 + 0x1b3), mod 2^64
	function automatic logic [KEY_W-1:0] mul_prime(input logic [KEY_W-1:0] h);
		mul_prime = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
	endfunction

endpackage

>>> rtl/voxel_hash_point_dedup.sv
// Voxel first-point filter.
// point channel: one point per item (Q16.16 x/y/z, frame_start); result
// channel: keep, set_full and the 64-bit voxel key, one result per point.
// Both channels move an item when valid is high and stall is low.
// cfg_wr_en/cfg_wr_data write inverse_leaf (Q16.16); write it only while idle.
// The hash runs, per axis, one multiply, one mix and one prime step.
// The voxel set is one 4096 x 72-bit synchronous RAM probed linearly, one slot
// per cycle; a free or matching home slot ends the probe, and up to 4096
// slots are probed when the set is full.
// A point is taken only while idle, after the previous one's result is
// loaded. The next point is taken while an earlier result still waits in
// the output register.
// Frame start bumps an 8-bit epoch held in each entry; slots of older
// epochs read as free. After reset, and on every frame start that wraps the
// epoch (every 255th), a pass clears all 4096 slots with point_stall high.
// A stalled result holds; once the waiting result and a finished one are both
// pending, point_stall stays high until the receiver takes the first.
`timescale 1ns / 1ps

module voxel_hash_point_dedup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  vhpd_pkg::point_t              point,
	output logic                          result_valid,
	input  logic                          result_stall,
	output vhpd_pkg::result_t             result,
	input  logic                          cfg_wr_en,
	input  logic [vhpd_pkg::LEAF_W-1:0]   cfg_wr_data
);
	import vhpd_pkg::*;

	state_t state_q, state_d;

	logic [LEAF_W-1:0]          inv_leaf_q;
	point_t                     pt_q;
	logic [1:0]                 axis_q;
	logic signed [COORD_W-1:0]  coord_sel;
	logic signed [COORD_W-1:0]  cell_q;
	logic signed [COORD_W+LEAF_W:0] prod;
	logic [KEY_W-1:0]           h_q, h_mix, h_mul;
	logic [EPOCH_W-1:0]         epoch_q;
	logic [SLOT_W-1:0]          addr_q;
	logic [SLOT_W-1:0]          probe_n_q;
	logic                       resume_q;

	entry_t                     mem [SET_CAPACITY];
	entry_t                     rd_q;
	entry_t                     mem_wd;
	logic                       mem_we;
	logic [SLOT_W-1:0]          mem_wa, mem_ra;

	logic                       can_load, res_load;
	logic                       slot_free, slot_hit, probe_last, probe_done;
	result_t                    res_d, pend_q, result_q;
	logic                       result_valid_q;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		case (axis_q)
			AXIS_X:  coord_sel = pt_q.pos_x;
			AXIS_Y:  coord_sel = pt_q.pos_y;
			default: coord_sel = pt_q.pos_z;
		endcase
	end

	assign prod  = coord_sel * $signed({1'b0, inv_leaf_q});
	assign h_mix = h_q ^ ({{(KEY_W-COORD_W){cell_q[COORD_W-1]}}, cell_q} + HASH_GOLDEN
		+ (h_q << 6) + (h_q >> 2));
	assign h_mul = mul_prime(h_q);

	assign slot_free  = rd_q.epoch != epoch_q;
	assign slot_hit   = !slot_free && (rd_q.key == h_q);
	assign probe_last = probe_n_q == '1;
	assign probe_done = slot_free || slot_hit || probe_last;

	assign res_d.keep      = !slot_hit;
	assign res_d.set_full  = !slot_free && !slot_hit;
	assign res_d.voxel_key = h_q;

	assign can_load = !result_valid_q || !result_stall;

	always_comb begin
		state_d     = state_q;
		point_stall = 1'b1;
		mem_we      = 1'b0;
		mem_wa      = addr_q;
		mem_wd      = '{epoch: epoch_q, key: h_q};
		mem_ra      = addr_q + 1'b1;
		res_load    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wd = '0;
				if (addr_q == '1) begin
					state_d = resume_q ? ST_MUL : ST_IDLE;
				end
			end
			ST_IDLE: begin
				point_stall = 1'b0;
				if (point_valid) begin
					state_d = (point.frame_start && epoch_q == EPOCH_LAST) ? ST_CLEAR : ST_MUL;
				end
			end
			ST_MUL: state_d = ST_MIX;
			ST_MIX: state_d = ST_PRIME;
			ST_PRIME: begin
				if (axis_q == AXIS_Z) begin
					state_d = ST_PROBE;
					mem_ra  = h_mul[SLOT_W-1:0];
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_PROBE: begin
				if (probe_done) begin
					mem_we = slot_free;
					if (can_load) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (can_load) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			addr_q         <= '0;
			resume_q       <= 1'b0;
			epoch_q        <= EPOCH_FIRST;
			inv_leaf_q     <= INV_LEAF_RESET;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				inv_leaf_q <= cfg_wr_data;
			end
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: addr_q <= addr_q + 1'b1;
				ST_IDLE: begin
					if (point_valid) begin
						resume_q <= 1'b1;
						if (point.frame_start) begin
							if (epoch_q == EPOCH_LAST) begin
								epoch_q <= EPOCH_FIRST;
								addr_q  <= '0;
							end else begin
								epoch_q <= epoch_q + 1'b1;
							end
						end
					end
				end
				ST_PRIME: begin
					if (axis_q == AXIS_Z) begin
						addr_q <= h_mul[SLOT_W-1:0];
					end
				end
				ST_PROBE: addr_q <= addr_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (point_valid) begin
					pt_q   <= point;
					axis_q <= AXIS_X;
					h_q    <= HASH_BASIS;
				end
			end
			ST_MUL: cell_q <= prod[COORD_W+LEAF_W-1:LEAF_W];
			ST_MIX: h_q <= h_mix;
			ST_PRIME: begin
				h_q       <= h_mul;
				axis_q    <= axis_q + 1'b1;
				probe_n_q <= '0;
			end
			ST_PROBE: begin
				probe_n_q <= probe_n_q + 1'b1;
				if (probe_done) begin
					pend_q <= res_d;
				end
			end
			default: ;
		endcase
		if (res_load) begin
			result_q <= (state_q == ST_HOLD) ? pend_q : res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

endmodule

>>> rtl/vhpd_checker.sv
`timescale 1ns / 1ps

module vhpd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              point_valid,
	input logic              point_stall,
	input logic              result_valid,
	input logic              result_stall,
	input vhpd_pkg::result_t result
);
	import vhpd_pkg::*;

	logic       point_acc, result_acc;
	logic [1:0] pend_q;

	assign point_acc  = point_valid && !point_stall;
	assign result_acc = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, point_acc} - {1'b0, result_acc};
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.set_full || result.keep))
		else $error("set_full without keep");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_acc |-> pend_q != 2'd0)
		else $error("result without a pending point");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		point_acc |-> pend_q != 2'd2)
		else $error("point taken with two items outstanding");

endmodule

bind voxel_hash_point_dedup vhpd_checker u_vhpd_checker (.*);
